@@ sv/three_axis_pid_servo_rate_core_assert.svh @@
// assertion macros for the three-axis pid servo rate core
// each expects clk and rst_n in the scope where it is used
`ifndef THREE_AXIS_PID_SERVO_RATE_CORE_ASSERT_SVH
`define THREE_AXIS_PID_SERVO_RATE_CORE_ASSERT_SVH

// condition implies consequence in the same cycle
`define TAPSR_ASSERT_SAME(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error("tapsr check failed");

// condition implies consequence in the next cycle
`define TAPSR_ASSERT_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error("tapsr check failed");

`endif

@@ sv/tapsr_pkg.sv @@
// ----------------------------------------------------------------------------
// tapsr_pkg
// shared types and constants of the three-axis pid servo rate core
// ----------------------------------------------------------------------------
`default_nettype none

package tapsr_pkg;

    localparam int AXES      = 3;
    localparam int NUM_SLOTS = 3;
    localparam int AXIS_W    = 2;

    localparam int ERR_W   = 16;
    localparam int DT_W    = 20;
    localparam int GAIN_W  = 16;
    localparam int GAINS_W = 48;
    localparam int LIM_W   = 10;
    localparam int RATE_W  = 11;
    localparam int INTEG_W = 40;
    localparam int DERIV_W = 37;
    localparam int PROD_W  = 37;
    localparam int MB_W    = 21;
    localparam int ACC_W   = 58;
    localparam int TOT_W   = 56;

    localparam int DIV_STEPS = 36;
    localparam int DIV_CNT_W = 6;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 40;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_GAINS_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_BASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_END        = 3'd6;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 10'd1023;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MEDT,
        OP_INT,
        OP_KIH,
        OP_KIL,
        OP_KIA,
        OP_KP,
        OP_KPA,
        OP_KDH,
        OP_KDL,
        OP_KDA,
        OP_SUB,
        OP_ABS,
        OP_COMMIT,
        OP_OUT
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEDT,
        ST_INT,
        ST_KIH,
        ST_KIL,
        ST_KIA,
        ST_KP,
        ST_KPA,
        ST_DWAIT,
        ST_KDH,
        ST_KDL,
        ST_KDA,
        ST_SUB,
        ST_ABS,
        ST_COMMIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t               op;
        logic [AXIS_W-1:0] axis;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
    } stat_t;

endpackage

`default_nettype wire

@@ sv/three_axis_pid_servo_rate_core.sv @@
// ----------------------------------------------------------------------------
// three_axis_pid_servo_rate_core
// three-axis pid rate controller with conditional-integration anti-windup
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one transfer per update: three signed errors and a step time.
//   m_axis returns one transfer per update: three rate codes and clamp flags.
//   cfg_wr_en writes gains (index 0..2) and limits (index 3..5); the user
//   writes them only while idle, which the block does not enforce.
//   the axes run one after another through one shared 16x21 multiplier and
//   a 36-step restoring divider for the derivative; the divider sets the pace
//   of each axis unless the step time is zero, which gives a zero quotient.
//   a new input is taken only between updates.
// reset
//   clears gains, integrals, previous errors and clamp history; limits go
//   to 1023.
// stall
//   a finished result sits in the output register; the next update is
//   accepted meanwhile and waits at the end until that result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module three_axis_pid_servo_rate_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // err_pitch, err_yaw, err_roll, step_time, zero pad
    input  wire logic [tapsr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // rate_pitch, rate_yaw, rate_roll, sat_pitch, sat_yaw, sat_roll, zero pad
    output logic      [tapsr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  wire logic                                cfg_wr_en,
    input  wire logic [tapsr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tapsr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    tapsr_pkg::cmd_t  cmd;
    tapsr_pkg::stat_t stat;

    tapsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    tapsr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_axis_tdata),
        .out_data  (m_axis_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

@@ sv/tapsr_div.sv @@
// ----------------------------------------------------------------------------
// tapsr_div
// restoring divider for the derivative: (diff * 2^20) / dt, toward zero
// ----------------------------------------------------------------------------
`default_nettype none

module tapsr_div (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic signed [tapsr_pkg::ERR_W:0]      diff,
    input  wire logic        [tapsr_pkg::DT_W-1:0]     dt,
    output logic                                       busy,
    output logic signed [tapsr_pkg::DERIV_W-1:0]       quot
);

    logic                                   busy_reg, busy_next;
    logic [tapsr_pkg::DIV_CNT_W-1:0]        cnt_reg, cnt_next;
    logic [tapsr_pkg::DIV_STEPS-1:0]        num_reg;
    logic [tapsr_pkg::DT_W-1:0]             rem_reg;
    logic                                   neg_reg;
    logic [tapsr_pkg::ERR_W:0]              diff_abs;
    logic [tapsr_pkg::DT_W:0]               rem_sh;
    logic [tapsr_pkg::DT_W:0]               rem_sub;
    logic                                   fits;

    always_comb
    begin
        diff_abs = diff[tapsr_pkg::ERR_W] ? (~diff + 1'b1) : diff;
        rem_sh   = {rem_reg, num_reg[tapsr_pkg::DIV_STEPS-1]};
        fits     = rem_sh >= {1'b0, dt};
        rem_sub  = rem_sh - {1'b0, dt};
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = dt != '0;
            cnt_next  = tapsr_pkg::DIV_CNT_W'(tapsr_pkg::DIV_STEPS);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == tapsr_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // zero step time leaves a zero quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            if (dt == '0)
            begin
                num_reg <= '0;
                neg_reg <= 1'b0;
            end
            else
            begin
                num_reg <= {diff_abs[tapsr_pkg::ERR_W-1:0], {tapsr_pkg::DT_W{1'b0}}};
                neg_reg <= diff[tapsr_pkg::ERR_W];
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sub[tapsr_pkg::DT_W-1:0] : rem_sh[tapsr_pkg::DT_W-1:0];
            num_reg <= {num_reg[tapsr_pkg::DIV_STEPS-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign quot = neg_reg ? -$signed({1'b0, num_reg}) : $signed({1'b0, num_reg});

endmodule

`default_nettype wire

@@ sv/tapsr_dp.sv @@
// ----------------------------------------------------------------------------
// tapsr_dp
// datapath: config registers, axis state, shared multiplier and accumulators
// ----------------------------------------------------------------------------
`default_nettype none

module tapsr_dp (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire tapsr_pkg::cmd_t                        cmd,
    output tapsr_pkg::stat_t                            stat,
    input  wire logic [tapsr_pkg::IN_DATA_W-1:0]        in_data,
    output logic      [tapsr_pkg::OUT_DATA_W-1:0]       out_data,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [tapsr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [tapsr_pkg::CFG_DATA_W-1:0]       cfg_data
);

    logic [tapsr_pkg::GAINS_W-1:0]          gains_reg [tapsr_pkg::NUM_SLOTS];
    logic [tapsr_pkg::LIM_W-1:0]            limit_reg [tapsr_pkg::NUM_SLOTS];
    logic signed [tapsr_pkg::INTEG_W-1:0]   integ_reg [tapsr_pkg::NUM_SLOTS];
    logic signed [tapsr_pkg::ERR_W-1:0]     prior_reg [tapsr_pkg::NUM_SLOTS];
    logic                                   satst_reg [tapsr_pkg::NUM_SLOTS];

    logic signed [tapsr_pkg::ERR_W-1:0]     err_reg [tapsr_pkg::NUM_SLOTS];
    logic [tapsr_pkg::DT_W-1:0]             dt_reg;
    logic [tapsr_pkg::RATE_W-1:0]           rate_reg [tapsr_pkg::NUM_SLOTS];
    logic                                   sat_reg [tapsr_pkg::NUM_SLOTS];
    logic [tapsr_pkg::OUT_DATA_W-1:0]       out_reg;

    logic signed [tapsr_pkg::PROD_W-1:0]    prod_reg;
    logic signed [tapsr_pkg::ACC_W-1:0]     acc_reg;
    logic signed [tapsr_pkg::TOT_W-1:0]     total_reg;
    logic [tapsr_pkg::TOT_W-1:0]            abs_reg;
    logic                                   neg_reg;

    logic [tapsr_pkg::AXIS_W-1:0]           ax;
    logic signed [tapsr_pkg::ERR_W-1:0]     e;
    logic signed [tapsr_pkg::GAIN_W-1:0]    kp, ki, kd;
    logic signed [tapsr_pkg::INTEG_W-1:0]   integ;
    logic signed [tapsr_pkg::DERIV_W-1:0]   deriv;
    logic signed [tapsr_pkg::INTEG_W-1:0]   dsx;
    logic signed [tapsr_pkg::GAIN_W-1:0]    mul_a;
    logic signed [tapsr_pkg::MB_W-1:0]      mul_b;
    logic signed [tapsr_pkg::PROD_W-1:0]    prod;
    logic signed [tapsr_pkg::INTEG_W:0]     isum;
    logic signed [tapsr_pkg::INTEG_W-1:0]   isat;
    logic signed [tapsr_pkg::ACC_W-1:0]     prod_ext;
    logic signed [tapsr_pkg::ACC_W-1:0]     tadj;
    logic [tapsr_pkg::TOT_W+9:0]            scaled;
    logic [tapsr_pkg::TOT_W-14:0]           mag_full;
    logic [tapsr_pkg::LIM_W-1:0]            lim;
    logic                                   clamp;
    logic [tapsr_pkg::LIM_W-1:0]            mag;
    logic                                   div_start;
    logic signed [tapsr_pkg::ERR_W:0]       diff;

    always_comb
    begin
        ax    = cmd.axis;
        e     = err_reg[ax];
        kp    = gains_reg[ax][15:0];
        ki    = gains_reg[ax][31:16];
        kd    = gains_reg[ax][47:32];
        integ = integ_reg[ax];
        lim   = limit_reg[ax];
        dsx   = {{(tapsr_pkg::INTEG_W-tapsr_pkg::DERIV_W){deriv[tapsr_pkg::DERIV_W-1]}}, deriv};
        diff  = {e[tapsr_pkg::ERR_W-1], e} - {prior_reg[ax][tapsr_pkg::ERR_W-1], prior_reg[ax]};
        div_start = cmd.op == tapsr_pkg::OP_INT;
    end

    // operand select for the shared multiplier
    always_comb
    begin
        unique case (cmd.op)
            tapsr_pkg::OP_MEDT:
            begin
                mul_a = e;
                mul_b = $signed({1'b0, dt_reg});
            end
            tapsr_pkg::OP_KIH:
            begin
                mul_a = ki;
                mul_b = $signed({integ[39], integ[39:20]});
            end
            tapsr_pkg::OP_KIL:
            begin
                mul_a = ki;
                mul_b = $signed({1'b0, integ[19:0]});
            end
            tapsr_pkg::OP_KP:
            begin
                mul_a = kp;
                mul_b = $signed({{(tapsr_pkg::MB_W-tapsr_pkg::ERR_W){e[15]}}, e});
            end
            tapsr_pkg::OP_KDH:
            begin
                mul_a = kd;
                mul_b = $signed({dsx[39], dsx[39:20]});
            end
            tapsr_pkg::OP_KDL:
            begin
                mul_a = kd;
                mul_b = $signed({1'b0, dsx[19:0]});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    always_comb
    begin
        isum = $signed({integ[39], integ})
             + $signed({{(tapsr_pkg::INTEG_W+1-tapsr_pkg::PROD_W){prod_reg[36]}}, prod_reg});
        // saturate to the 40-bit signed range
        unique case (isum[40:39])
            2'b01:   isat = {1'b0, {(tapsr_pkg::INTEG_W-1){1'b1}}};
            2'b10:   isat = {1'b1, {(tapsr_pkg::INTEG_W-1){1'b0}}};
            default: isat = isum[39:0];
        endcase
        prod_ext = {{(tapsr_pkg::ACC_W-tapsr_pkg::PROD_W){prod_reg[36]}}, prod_reg};
        // round toward zero when dropping 20 fraction bits
        tadj = acc_reg + (acc_reg[tapsr_pkg::ACC_W-1] ? 58'sd1048575 : 58'sd0);
        scaled   = {abs_reg, 10'b0} - {10'b0, abs_reg};
        mag_full = scaled[tapsr_pkg::TOT_W+9:23];
        clamp    = mag_full > {{(tapsr_pkg::TOT_W-13-tapsr_pkg::LIM_W){1'b0}}, lim};
        mag      = clamp ? lim : mag_full[tapsr_pkg::LIM_W-1:0];
    end

    tapsr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .diff  (diff),
        .dt    (dt_reg),
        .busy  (stat.div_busy),
        .quot  (deriv)
    );

    // configuration and per-axis state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tapsr_pkg::NUM_SLOTS; i++)
            begin
                gains_reg[i] <= '0;
                limit_reg[i] <= tapsr_pkg::LIMIT_RESET;
                integ_reg[i] <= '0;
                prior_reg[i] <= '0;
                satst_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                priority if (cfg_index < tapsr_pkg::REG_LIMIT_BASE)
                begin
                    gains_reg[tapsr_pkg::AXIS_W'(cfg_index - tapsr_pkg::REG_GAINS_BASE)]
                        <= cfg_data;
                end
                else if (cfg_index < tapsr_pkg::REG_END)
                begin
                    limit_reg[tapsr_pkg::AXIS_W'(cfg_index - tapsr_pkg::REG_LIMIT_BASE)]
                        <= cfg_data[tapsr_pkg::LIM_W-1:0];
                end
                else
                begin
                    // index out of range: write ignored
                end
            end
            if (cmd.op == tapsr_pkg::OP_INT)
            begin
                if (ki == '0)
                begin
                    integ_reg[ax] <= '0;
                end
                else if (!satst_reg[ax])
                begin
                    integ_reg[ax] <= isat;
                end
            end
            if (cmd.op == tapsr_pkg::OP_COMMIT)
            begin
                satst_reg[ax] <= clamp;
                prior_reg[ax] <= e;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            tapsr_pkg::OP_LOAD:
            begin
                for (int i = 0; i < tapsr_pkg::NUM_SLOTS; i++)
                begin
                    err_reg[i]  <= in_data[i*tapsr_pkg::ERR_W +: tapsr_pkg::ERR_W];
                    rate_reg[i] <= '0;
                    sat_reg[i]  <= 1'b0;
                end
                dt_reg <= in_data[tapsr_pkg::NUM_SLOTS*tapsr_pkg::ERR_W +: tapsr_pkg::DT_W];
            end
            tapsr_pkg::OP_MEDT, tapsr_pkg::OP_KIH, tapsr_pkg::OP_KDH:
            begin
                prod_reg <= prod;
            end
            tapsr_pkg::OP_KIL, tapsr_pkg::OP_KDL:
            begin
                acc_reg  <= prod_ext <<< 20;
                prod_reg <= prod;
            end
            tapsr_pkg::OP_KIA, tapsr_pkg::OP_KDA:
            begin
                acc_reg <= acc_reg + prod_ext;
            end
            tapsr_pkg::OP_KP:
            begin
                total_reg <= {{(tapsr_pkg::TOT_W-38){tadj[57]}}, tadj[57:20]};
                prod_reg  <= prod;
            end
            tapsr_pkg::OP_KPA:
            begin
                total_reg <= total_reg + prod_ext[tapsr_pkg::TOT_W-1:0];
            end
            tapsr_pkg::OP_SUB:
            begin
                total_reg <= total_reg - acc_reg[tapsr_pkg::TOT_W-1:0];
            end
            tapsr_pkg::OP_ABS:
            begin
                neg_reg <= total_reg[tapsr_pkg::TOT_W-1];
                abs_reg <= total_reg[tapsr_pkg::TOT_W-1] ? -total_reg : total_reg;
            end
            tapsr_pkg::OP_COMMIT:
            begin
                rate_reg[ax] <= {neg_reg, mag};
                sat_reg[ax]  <= clamp;
            end
            tapsr_pkg::OP_OUT:
            begin
                out_reg <= {4'b0, sat_reg[2], sat_reg[1], sat_reg[0],
                            rate_reg[2], rate_reg[1], rate_reg[0]};
            end
            default:
            begin
            end
        endcase
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

@@ sv/tapsr_ctrl.sv @@
// ----------------------------------------------------------------------------
// tapsr_ctrl
// sequencer: walks each axis through the pid steps, owns the stream handshakes
// ----------------------------------------------------------------------------
`default_nettype none

module tapsr_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output tapsr_pkg::cmd_t          cmd,
    input  wire tapsr_pkg::stat_t    stat
);

    tapsr_pkg::state_t                  state_reg, state_next;
    logic [tapsr_pkg::AXIS_W-1:0]       axis_reg, axis_next;
    logic                               ovalid_reg, ovalid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tapsr_pkg::ST_IDLE;
            axis_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            axis_reg   <= axis_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        axis_next   = axis_reg;
        ovalid_next = ovalid_reg;
        in_ready    = 1'b0;
        cmd.op      = tapsr_pkg::OP_NONE;
        cmd.axis    = axis_reg;
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            tapsr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = tapsr_pkg::OP_LOAD;
                    axis_next  = '0;
                    state_next = tapsr_pkg::ST_MEDT;
                end
            end
            tapsr_pkg::ST_MEDT:
            begin
                cmd.op     = tapsr_pkg::OP_MEDT;
                state_next = tapsr_pkg::ST_INT;
            end
            tapsr_pkg::ST_INT:
            begin
                cmd.op     = tapsr_pkg::OP_INT;
                state_next = tapsr_pkg::ST_KIH;
            end
            tapsr_pkg::ST_KIH:
            begin
                cmd.op     = tapsr_pkg::OP_KIH;
                state_next = tapsr_pkg::ST_KIL;
            end
            tapsr_pkg::ST_KIL:
            begin
                cmd.op     = tapsr_pkg::OP_KIL;
                state_next = tapsr_pkg::ST_KIA;
            end
            tapsr_pkg::ST_KIA:
            begin
                cmd.op     = tapsr_pkg::OP_KIA;
                state_next = tapsr_pkg::ST_KP;
            end
            tapsr_pkg::ST_KP:
            begin
                cmd.op     = tapsr_pkg::OP_KP;
                state_next = tapsr_pkg::ST_KPA;
            end
            tapsr_pkg::ST_KPA:
            begin
                cmd.op     = tapsr_pkg::OP_KPA;
                state_next = tapsr_pkg::ST_DWAIT;
            end
            tapsr_pkg::ST_DWAIT:
            begin
                // derivative quotient must be settled
                if (!stat.div_busy)
                begin
                    state_next = tapsr_pkg::ST_KDH;
                end
            end
            tapsr_pkg::ST_KDH:
            begin
                cmd.op     = tapsr_pkg::OP_KDH;
                state_next = tapsr_pkg::ST_KDL;
            end
            tapsr_pkg::ST_KDL:
            begin
                cmd.op     = tapsr_pkg::OP_KDL;
                state_next = tapsr_pkg::ST_KDA;
            end
            tapsr_pkg::ST_KDA:
            begin
                cmd.op     = tapsr_pkg::OP_KDA;
                state_next = tapsr_pkg::ST_SUB;
            end
            tapsr_pkg::ST_SUB:
            begin
                cmd.op     = tapsr_pkg::OP_SUB;
                state_next = tapsr_pkg::ST_ABS;
            end
            tapsr_pkg::ST_ABS:
            begin
                cmd.op     = tapsr_pkg::OP_ABS;
                state_next = tapsr_pkg::ST_COMMIT;
            end
            tapsr_pkg::ST_COMMIT:
            begin
                cmd.op = tapsr_pkg::OP_COMMIT;
                if (axis_reg == tapsr_pkg::AXIS_W'(tapsr_pkg::AXES - 1))
                begin
                    state_next = tapsr_pkg::ST_DONE;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = tapsr_pkg::ST_MEDT;
                end
            end
            tapsr_pkg::ST_DONE:
            begin
                // wait until the output register is free
                if (!ovalid_reg || out_ready)
                begin
                    cmd.op      = tapsr_pkg::OP_OUT;
                    ovalid_next = 1'b1;
                    state_next  = tapsr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tapsr_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = ovalid_reg;

endmodule

`default_nettype wire

@@ sv/tapsr_checker.sv @@
// ----------------------------------------------------------------------------
// tapsr_checker
// port-level checks on the three-axis pid servo rate core
// ----------------------------------------------------------------------------
`default_nettype none

`include "three_axis_pid_servo_rate_core_assert.svh"

module tapsr_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                s_axis_tvalid,
    input wire logic                                s_axis_tready,
    input wire logic                                m_axis_tvalid,
    input wire logic                                m_axis_tready,
    input wire logic [tapsr_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    // stalled result holds
    `TAPSR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // one update at a time: an input transfer closes the input side
    `TAPSR_ASSERT_NEXT(a_in_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // padding above the result fields stays zero
    `TAPSR_ASSERT_SAME(a_out_pad, m_axis_tvalid, m_axis_tdata[39:36] == 4'b0)

endmodule

bind three_axis_pid_servo_rate_core tapsr_checker u_tapsr_checker (.*);

`default_nettype wire
